### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/updc_pkg.sv
// ----------------------------------------------------------------------------
// updc_pkg
// Shared types and constants of the up/down counter display block.
// ----------------------------------------------------------------------------
package updc_pkg;

    localparam int COUNT_W = 16;
    localparam int MV_W    = 13;
    localparam int POS_W   = 3;
    localparam int DIGIT_W = 4;
    localparam int M_DATA_W = 8;

    // Request kinds carried on s_tuser.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // floor(x / d) == (x * ceil(2^SHIFT / d)) >> SHIFT holds for every 16-bit x
    // and d up to 1000 with this shift.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_1    = RECIP_W'(2 ** RECIP_SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_10   = RECIP_W'((2 ** RECIP_SHIFT + 9) / 10);
    localparam logic [RECIP_W-1:0] RECIP_100  = RECIP_W'((2 ** RECIP_SHIFT + 99) / 100);
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'((2 ** RECIP_SHIFT + 999) / 1000);

    // Decoded command passed from the front end to the back end.
    typedef struct packed {
        logic            is_step;
        logic [MV_W-1:0] mv;
        logic            level;
    } cmd_t;

    function automatic logic [RECIP_W-1:0] digit_recip(input logic [1:0] idx);
        logic [RECIP_W-1:0] r;
        case (idx)
            2'd0:    r = RECIP_1;
            2'd1:    r = RECIP_10;
            2'd2:    r = RECIP_100;
            default: r = RECIP_1000;
        endcase
        return r;
    endfunction

endpackage

### rtl/updown_counter_display_mux.sv
// ----------------------------------------------------------------------------
// updown_counter_display_mux
// Up/down counter with millivolt readout and a multiplexed four-digit display.
// ----------------------------------------------------------------------------
// The block takes one item per clock while m_tready stays high. A tick item
// (s_tuser low) steps the 16-bit counter and latches the millivolt value of
// its sample; it produces no output. A loop-step item (s_tuser high) samples
// the direction button and produces one display digit once it has passed
// through the input register, the two-entry command queue and the four
// digit pipeline registers. The two reciprocal multiplies in that pipeline
// set the latency. Ticks drain from the queue even while the output is
// stalled.
module updown_counter_display_mux #(
    parameter int ADC_BITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // adc_sample [ADC_BITS-1:0], button_level [ADC_BITS], zero fill above
    input  logic [((ADC_BITS + 8) / 8) * 8 - 1:0]  s_tdata,
    // req_type
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // digit_position [2:0], digit_value [6:3], zero fill at [7]
    output logic [updc_pkg::M_DATA_W-1:0]          m_tdata
);
    import updc_pkg::*;

    localparam int S_DATA_W = ((ADC_BITS + 8) / 8) * 8;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    updc_front #(
        .ADC_BITS (ADC_BITS),
        .S_DATA_W (S_DATA_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    updc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    updc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/updc_front.sv
// ----------------------------------------------------------------------------
// updc_front
// Accepts input items, decodes the request kind and converts the sample
// to millivolts, then hands a command to the queue.
// ----------------------------------------------------------------------------
module updc_front #(
    parameter int ADC_BITS = 10,
    parameter int S_DATA_W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output updc_pkg::cmd_t        cmd
);
    import updc_pkg::*;

    localparam int PROD_W = ADC_BITS + MV_W;

    logic               valid_reg;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [ADC_BITS-1:0] sample;
    logic [PROD_W-1:0]   prod;

    assign s_tready = !valid_reg || cmd_ready;
    assign sample   = s_tdata[ADC_BITS-1:0];
    // 5000 fits in 13 bits, so the scaled value never exceeds the product width.
    assign prod     = PROD_W'(sample) * PROD_W'(5000);

    always_comb begin
        cmd_next.is_step = (s_tuser == REQ_STEP);
        cmd_next.mv      = prod[ADC_BITS +: MV_W];
        cmd_next.level   = s_tdata[ADC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### rtl/updc_queue.sv
// ----------------------------------------------------------------------------
// updc_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module updc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  updc_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output updc_pkg::cmd_t out_cmd
);
    import updc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### rtl/updc_back.sv
// ----------------------------------------------------------------------------
// updc_back
// Executes commands against the counter state and extracts the display
// digit in a reciprocal-multiply pipeline.
// ----------------------------------------------------------------------------
module updc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  updc_pkg::cmd_t                cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [updc_pkg::M_DATA_W-1:0] m_tdata
);
    import updc_pkg::*;

    // Architectural state.
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [3:0]         mod10_reg,    mod10_next;
    logic               count_up_reg, count_up_next;
    logic               btn_prev_reg, btn_prev_next;
    logic [1:0]         idx_reg,      idx_next;
    logic [MV_W-1:0]    mv_reg,       mv_next;
    logic               show_reg,     show_next;

    // Digit pipeline.
    logic               advance;
    logic               step_pop;
    logic               tick_pop;
    logic               p1_valid_reg;
    logic [COUNT_W-1:0] p1_src_reg;
    logic [1:0]         p1_idx_reg;
    logic               p2_valid_reg;
    logic [COUNT_W-1:0] p2_q_reg;
    logic [1:0]         p2_idx_reg;
    logic               p3_valid_reg;
    logic [3:0]         p3_q_lo_reg;
    logic [3:0]         p3_q10_lo_reg;
    logic [1:0]         p3_idx_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [DIGIT_W-1:0] out_digit_reg;

    logic [COUNT_W+RECIP_W-1:0] prod1;
    logic [2*COUNT_W+6:0]       prod2;
    logic [12:0]                q10;
    logic [3:0]                 digit;

    assign advance   = !out_valid_reg || m_tready;
    // Ticks produce no digit, so they drain even while the output is stalled.
    assign cmd_ready = !cmd.is_step || advance;
    assign step_pop  = cmd_valid && cmd.is_step && advance;
    assign tick_pop  = cmd_valid && !cmd.is_step;

    always_comb begin
        count_next    = count_reg;
        mod10_next    = mod10_reg;
        count_up_next = count_up_reg;
        btn_prev_next = btn_prev_reg;
        idx_next      = idx_reg;
        mv_next       = mv_reg;
        show_next     = show_reg;
        if (tick_pop) begin
            if (count_up_reg) begin
                if (count_reg == '1) begin
                    count_next = '0;
                    mod10_next = 4'd0;
                end else begin
                    count_next = count_reg + 1'b1;
                    mod10_next = (mod10_reg == 4'd9) ? 4'd0 : mod10_reg + 4'd1;
                end
            end else if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
                mod10_next = (mod10_reg == 4'd0) ? 4'd9 : mod10_reg - 4'd1;
            end
            mv_next   = cmd.mv;
            show_next = (mod10_next == 4'd0);
        end
        if (step_pop) begin
            if (cmd.level) begin
                if (!btn_prev_reg) begin
                    btn_prev_next = 1'b1;
                    count_up_next = !count_up_reg;
                end
            end else begin
                btn_prev_next = 1'b0;
            end
            idx_next = idx_reg + 2'd1;
        end
    end

    // q = src / 10^idx, then q10 = q / 10, and the digit is q - 10 * q10.
    assign prod1 = (COUNT_W+RECIP_W)'(p1_src_reg) * (COUNT_W+RECIP_W)'(digit_recip(p1_idx_reg));
    assign prod2 = (2*COUNT_W+7)'(p2_q_reg) * (2*COUNT_W+7)'(RECIP_10);
    assign q10   = prod2[RECIP_SHIFT +: 13];
    assign digit = p3_q_lo_reg - ((p3_q10_lo_reg << 3) + (p3_q10_lo_reg << 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            mod10_reg     <= 4'd0;
            count_up_reg  <= 1'b1;
            btn_prev_reg  <= 1'b0;
            idx_reg       <= 2'd0;
            mv_reg        <= '0;
            show_reg      <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            mod10_reg    <= mod10_next;
            count_up_reg <= count_up_next;
            btn_prev_reg <= btn_prev_next;
            idx_reg      <= idx_next;
            mv_reg       <= mv_next;
            show_reg     <= show_next;
            if (advance) begin
                p1_valid_reg  <= step_pop;
                p2_valid_reg  <= p1_valid_reg;
                p3_valid_reg  <= p2_valid_reg;
                out_valid_reg <= p3_valid_reg;
            end
        end
        if (advance) begin
            p1_src_reg    <= show_reg ? COUNT_W'(mv_reg) : count_reg;
            p1_idx_reg    <= idx_reg;
            p2_q_reg      <= prod1[RECIP_SHIFT +: COUNT_W];
            p2_idx_reg    <= p1_idx_reg;
            p3_q_lo_reg   <= p2_q_reg[3:0];
            p3_q10_lo_reg <= q10[3:0];
            p3_idx_reg    <= p2_idx_reg;
            out_pos_reg   <= POS_W'(p3_idx_reg) + POS_W'(1);
            out_digit_reg <= digit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_digit_reg, out_pos_reg};

endmodule

### rtl/updc_checker.sv
// ----------------------------------------------------------------------------
// updc_checker
// Port-level checks of the display digit stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module updc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [updc_pkg::M_DATA_W-1:0] m_tdata
);
    import updc_pkg::*;

    logic             m_accept;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] expect_pos_reg;

    assign m_accept = m_tvalid && m_tready;
    assign pos      = m_tdata[POS_W-1:0];

    // Positions are delivered as 1, 2, 3, 4 and then start over.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_pos_reg <= POS_W'(1);
        end else if (m_accept) begin
            expect_pos_reg <= (pos == POS_W'(4)) ? POS_W'(1) : pos + POS_W'(1);
        end
    end

    `ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLIES(a_digit_range, aclk, aresetn, m_tvalid, m_tdata[POS_W +: DIGIT_W] <= 4'd9)
    `ASSERT_IMPLIES(a_pos_order, aclk, aresetn, m_accept, pos == expect_pos_reg)
    `ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)

endmodule

bind updown_counter_display_mux updc_checker u_updc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
